/* src/mwpo_pkg.sv */
`default_nettype none

package mwpo_pkg;

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_SQUARE   = 3'd1,
		WAVE_SAW      = 3'd2,
		WAVE_TRIANGLE = 3'd3,
		WAVE_NOISE    = 3'd4
	} wave_t;

	typedef enum logic [1:0] {
		CFG_WAVEFORM   = 2'd0,
		CFG_PHASE_STEP = 2'd1,
		CFG_AMPLITUDE  = 2'd2,
		CFG_CHANNELS   = 2'd3
	} cfg_idx_t;

	localparam int MIX_W      = 24;
	localparam int SAMPLE_W   = 17;
	localparam int AMP_W      = 15;
	localparam int STEP_W     = 24;
	localparam int CHAN_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_MIX    = 2;
	localparam int ROM_W      = 15;

	typedef logic signed [MIX_W-1:0]    mix_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam logic [31:0]       LFSR_SEED  = 32'hACE1ACE1;
	localparam logic [31:0]       LFSR_TAPS  = 32'h80200003;
	localparam logic [AMP_W-1:0]  AMP_RESET  = 15'd16384;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
	localparam mix_t              MIX_MAX    = 24'sh7FFFFF;
	localparam mix_t              MIX_MIN    = -24'sh800000;

	// quarter-wave sine entry from x = k/depth in Q30, degree 7 odd polynomial
	function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] y;
		x2 = (x * x) >> 30;
		p  = 64'd5026995;
		p  = 64'd85569306 - ((x2 * p) >> 30);
		p  = 64'd693598669 - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		y  = (x * p) >> 30;
		y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
		if (y > 64'd32767) y = 64'd32767;
		return y[ROM_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/mwpo_frame_if.sv */
`default_nettype none

interface mwpo_frame_if;
	logic          valid;
	logic          ready;
	mwpo_pkg::mix_t mix_in_ch0;
	mwpo_pkg::mix_t mix_in_ch1;
	logic          frame_last;

	modport source (output valid, output mix_in_ch0, output mix_in_ch1, output frame_last,
		input ready);
	modport sink (input valid, input mix_in_ch0, input mix_in_ch1, input frame_last,
		output ready);
endinterface

`default_nettype wire

/* src/mwpo_result_if.sv */
`default_nettype none

interface mwpo_result_if;
	logic          valid;
	logic          ready;
	mwpo_pkg::mix_t mix_out_ch0;
	mwpo_pkg::mix_t mix_out_ch1;
	logic          end_of_buffer;

	modport source (output valid, output mix_out_ch0, output mix_out_ch1,
		output end_of_buffer, input ready);
	modport sink (input valid, input mix_out_ch0, input mix_out_ch1,
		input end_of_buffer, output ready);
endinterface

`default_nettype wire

/* src/mwpo_wave.sv */
`default_nettype none

module mwpo_wave #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic                    advance,
	input  wire logic [PHASE_BITS-1:0]   phase,
	input  wire mwpo_pkg::wave_t         waveform,
	output mwpo_pkg::sample_t            sample
);

	localparam int QBITS = PHASE_BITS - 2;
	localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW    = QBITS + AW;

	logic [mwpo_pkg::ROM_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [63:0] X = (64'(k) << 30) / SINE_TABLE_DEPTH;
		assign sine_rom[k] = mwpo_pkg::sine_entry(X);
	end

	logic [1:0]       quarter;
	logic [PW-1:0]    idx_prod;
	logic [AW-1:0]    idx;
	logic [AW-1:0]    addr;
	logic [15:0]      u;
	logic [31:0]      lfsr_q;
	logic [31:0]      lfsr_nx;
	logic signed [17:0] two_u;
	logic signed [17:0] tri_lo;
	logic signed [17:0] tri_hi;
	mwpo_pkg::sample_t  other;

	logic [mwpo_pkg::ROM_W-1:0] rom_s1;
	logic                       neg_s1;
	logic                       sine_s1;
	mwpo_pkg::sample_t          other_s1;
	mwpo_pkg::sample_t          rom_ext;

	assign quarter  = phase[PHASE_BITS-1 -: 2];
	assign idx_prod = PW'(phase[QBITS-1:0]) * PW'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[PW-1:QBITS];
	// odd quarters run the table backwards
	assign addr     = quarter[0] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;

	assign u       = phase[PHASE_BITS-1 -: 16];
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ mwpo_pkg::LFSR_TAPS) : (lfsr_q >> 1);
	assign two_u   = $signed({1'b0, u, 1'b0});
	assign tri_lo  = two_u - 18'sd32768;
	assign tri_hi  = 18'sd98304 - two_u;

	always_comb begin
		case (waveform)
			mwpo_pkg::WAVE_SQUARE:
				other = u[15] ? -17'sd32767 : 17'sd32767;
			mwpo_pkg::WAVE_SAW:
				other = $signed({~u[15], ~u[15], u[14:0]});
			mwpo_pkg::WAVE_TRIANGLE: begin
				if (!u[15]) other = $signed(tri_lo[16:0]);
				else if (tri_hi > 18'sd32767) other = 17'sd32767;
				else other = $signed(tri_hi[16:0]);
			end
			mwpo_pkg::WAVE_NOISE:
				other = $signed({lfsr_nx[31], lfsr_nx[31:16]});
			default:
				other = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= mwpo_pkg::LFSR_SEED;
		end else if (accept && waveform == mwpo_pkg::WAVE_NOISE) begin
			lfsr_q <= lfsr_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rom_s1   <= sine_rom[addr];
			neg_s1   <= quarter[1];
			sine_s1  <= (waveform == mwpo_pkg::WAVE_SINE);
			other_s1 <= other;
		end
	end

	assign rom_ext = $signed({2'b00, rom_s1});
	assign sample  = sine_s1 ? (neg_s1 ? -rom_ext : rom_ext) : other_s1;

endmodule

`default_nettype wire

/* src/mwpo_lane.sv */
`default_nettype none

module mwpo_lane (
	input  wire mwpo_pkg::mix_t    mix,
	input  wire mwpo_pkg::sample_t scaled,
	input  wire logic              active,
	output mwpo_pkg::mix_t         result
);

	logic signed [mwpo_pkg::MIX_W:0] sum;
	mwpo_pkg::mix_t                  sat;

	assign sum = (mwpo_pkg::MIX_W+1)'(mix) + (mwpo_pkg::MIX_W+1)'(scaled);

	always_comb begin
		if (sum > (mwpo_pkg::MIX_W+1)'(mwpo_pkg::MIX_MAX)) sat = mwpo_pkg::MIX_MAX;
		else if (sum < (mwpo_pkg::MIX_W+1)'(mwpo_pkg::MIX_MIN)) sat = mwpo_pkg::MIX_MIN;
		else sat = sum[mwpo_pkg::MIX_W-1:0];
	end

	assign result = active ? sat : mix;

endmodule

`default_nettype wire

/* src/multi_waveform_phase_oscillator_top.sv */
// Phase-accumulator oscillator that adds a sine, square, saw, triangle or noise
// sample, scaled by the amplitude register, into the mix of each active channel.
// frames: one beat per audio frame with the mix samples of both channels and a
// last-frame flag. results: one beat per frame, in order, same flag copied.
// Config: write cfg_data to register cfg_index while cfg_we is high; write only
// when no frame is in flight.
// Path: a taken frame beat passes the registered sine table read, the amplitude
// multiplier stage and the lane add/saturate stage before its result is on the
// results port. Throughput: one frame per cycle while results.ready is high.
// Stall: each of the three stages holds its beat while the next one is full, so
// up to three frames are absorbed before frames.ready drops.
// Reset: phase goes to zero, the noise register to its seed, the registers to
// sine, zero step, half amplitude and two channels; the pipeline is empty and
// frames.ready is high right after reset.
`default_nettype none

module multi_waveform_phase_oscillator_top #(
	parameter int CHANNELS         = 2,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mwpo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mwpo_pkg::CFG_DATA_W-1:0]   cfg_data,
	mwpo_frame_if.sink                             frames,
	mwpo_result_if.source                          results
);

	mwpo_pkg::wave_t                 waveform_q;
	logic [mwpo_pkg::STEP_W-1:0]     phase_step_q;
	logic [mwpo_pkg::AMP_W-1:0]      amplitude_q;
	logic [mwpo_pkg::CHAN_W-1:0]     chan_q;
	logic [PHASE_BITS-1:0]           phase_q;
	logic [PHASE_BITS-1:0]           step;

	logic ready_out;
	logic ready_s2;
	logic advance;
	logic accept;

	logic                v_s1;
	mwpo_pkg::mix_t      mix_s1 [mwpo_pkg::NUM_MIX];
	logic                last_s1;
	mwpo_pkg::sample_t   sample;

	logic                v_s2;
	mwpo_pkg::mix_t      mix_s2 [mwpo_pkg::NUM_MIX];
	logic                last_s2;
	mwpo_pkg::sample_t   scaled_s2;

	logic                out_v_q;
	mwpo_pkg::mix_t      out_mix_q [mwpo_pkg::NUM_MIX];
	logic                out_last_q;
	mwpo_pkg::mix_t      lane_res [mwpo_pkg::NUM_MIX];

	logic signed [32:0]  sample_ext;
	logic signed [32:0]  amp_ext;
	logic signed [32:0]  prod;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= mwpo_pkg::WAVE_SINE;
			phase_step_q <= '0;
			amplitude_q  <= mwpo_pkg::AMP_RESET;
			chan_q       <= mwpo_pkg::CHAN_RESET;
		end else if (cfg_we) begin
			case (mwpo_pkg::cfg_idx_t'(cfg_index))
				mwpo_pkg::CFG_WAVEFORM:   waveform_q   <= mwpo_pkg::wave_t'(cfg_data[2:0]);
				mwpo_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data[mwpo_pkg::STEP_W-1:0];
				mwpo_pkg::CFG_AMPLITUDE:  amplitude_q  <= cfg_data[mwpo_pkg::AMP_W-1:0];
				mwpo_pkg::CFG_CHANNELS:   chan_q       <= cfg_data[mwpo_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// step register is Q0.24, align it to the accumulator width
	if (PHASE_BITS >= mwpo_pkg::STEP_W) begin : g_step_wide
		assign step = PHASE_BITS'(phase_step_q) << (PHASE_BITS - mwpo_pkg::STEP_W);
	end else begin : g_step_narrow
		assign step = phase_step_q[mwpo_pkg::STEP_W-1 -: PHASE_BITS];
	end

	assign ready_out    = !out_v_q || results.ready;
	assign ready_s2     = !v_s2 || ready_out;
	assign advance      = !v_s1 || ready_s2;
	assign frames.ready = advance;
	assign accept       = frames.valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_q + step;
		end
	end

	mwpo_wave #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_BITS       (PHASE_BITS)
	) u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.advance  (advance),
		.phase    (phase_q),
		.waveform (waveform_q),
		.sample   (sample)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (advance) v_s1 <= frames.valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_out) out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mix_s1[0] <= frames.mix_in_ch0;
			mix_s1[1] <= frames.mix_in_ch1;
			last_s1   <= frames.frame_last;
		end
	end

	// floor((sample * amplitude + half) / 2^15)
	assign sample_ext = 33'(sample);
	assign amp_ext    = $signed({18'd0, amplitude_q});
	assign prod       = sample_ext * amp_ext + 33'sd16384;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			mix_s2    <= mix_s1;
			last_s2   <= last_s1;
			scaled_s2 <= $signed(prod[31:15]);
		end
	end

	for (genvar ch = 0; ch < mwpo_pkg::NUM_MIX; ch++) begin : g_lane
		if (ch < CHANNELS) begin : g_core
			mwpo_lane u_lane (
				.mix    (mix_s2[ch]),
				.scaled (scaled_s2),
				.active (int'(chan_q) > ch),
				.result (lane_res[ch])
			);
		end else begin : g_pass
			assign lane_res[ch] = mix_s2[ch];
		end
	end

	// merge lane results into the output beat
	always_ff @(posedge clk) begin
		if (ready_out) begin
			out_mix_q  <= lane_res;
			out_last_q <= last_s2;
		end
	end

	assign results.valid         = out_v_q;
	assign results.mix_out_ch0   = out_mix_q[0];
	assign results.mix_out_ch1   = out_mix_q[1];
	assign results.end_of_buffer = out_last_q;

`ifndef SYNTHESIS
	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> phase_q == $past(phase_q + step))
		else $error("phase did not advance by the step on an accepted frame");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("phase moved without an accepted frame");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s2))
		else $error("output beat appeared without a frame in the scale stage");

	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ready_out) |=> out_v_q)
		else $error("frame lost between scale stage and output register");
`endif

endmodule

`default_nettype wire
